// ===== rtl/clcd_pkg.sv =====
// shared types and constants for the character lcd sequencer
package clcd_pkg;

  // item kinds
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // lcd command bytes
  localparam logic [7:0] CMD_FUNC_SET   = 8'h38;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] CMD_DISP_ON    = 8'h0F;
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] DDRAM_ROW0     = 8'h80;
  localparam logic [7:0] DDRAM_ROW1     = 8'hB8;

  localparam logic [7:0] PU_WAIT_RST = 8'd10;

  // buffer geometry, fixed by the 4-bit buffer address
  localparam int BUF_DEPTH = 16;
  localparam int BUF_AW    = 4;
  localparam int COL_W     = 5;
  localparam int ROW_SPLIT = 8;

  // pin levels and flags after one beat
  typedef struct packed {
    logic [7:0] data;
    logic       rs;
    logic       e;
    logic       fell;
    logic       ready;
  } clcd_res_t;

endpackage

// ===== rtl/clcd_seq.sv =====
// init and write sequencer state machine for the character lcd bus
module clcd_seq #(
  parameter int COLUMNS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic                          go,
  input  logic [7:0]                    power_up_wait,
  output logic [clcd_pkg::BUF_AW-1:0]   buf_addr,
  input  logic [7:0]                    buf_rdata,
  output clcd_pkg::clcd_res_t           res
);

  typedef enum logic [3:0] {
    PH_PRE    = 4'd0,
    PH_INIT1  = 4'd1,
    PH_WAITPU = 4'd2,
    PH_FUNC   = 4'd3,
    PH_ENTRY  = 4'd4,
    PH_DISPON = 4'd5,
    PH_CLR0   = 4'd6,
    PH_READY  = 4'd7,
    PH_CLR    = 4'd8,
    PH_CURSOR = 4'd9,
    PH_CHAR   = 4'd10,
    PH_HOLD   = 4'd11
  } phase_t;

  localparam logic [clcd_pkg::COL_W-1:0] COL_LAST  = clcd_pkg::COL_W'(COLUMNS);
  localparam logic [clcd_pkg::COL_W-1:0] COL_SPLIT = clcd_pkg::COL_W'(clcd_pkg::ROW_SPLIT);

  phase_t                       phase_r, phase_mid, phase_nxt;
  logic [clcd_pkg::COL_W-1:0]   col_r, col_nxt;
  logic [7:0]                   wait_r, wait_nxt;
  logic [7:0]                   data_r, data_nxt;
  logic                         rs_r, rs_nxt;
  logic                         e_r, e_nxt;
  logic                         ready_r, ready_nxt;
  logic                         fell;

  assign buf_addr = col_nxt[clcd_pkg::BUF_AW-1:0];

  always_comb begin
    phase_mid = phase_r;
    col_nxt   = col_r;
    wait_nxt  = wait_r;
    data_nxt  = data_r;
    rs_nxt    = rs_r;
    e_nxt     = e_r;
    ready_nxt = ready_r;
    fell      = 1'b0;

    // leave the current phase
    unique case (phase_r)
      PH_PRE:    phase_mid = PH_INIT1;
      PH_INIT1: begin
        phase_mid = PH_WAITPU;
        wait_nxt  = '0;
      end
      PH_WAITPU: begin
        if (wait_r >= power_up_wait) phase_mid = PH_FUNC;
      end
      PH_FUNC: begin
        phase_mid = PH_ENTRY;
        e_nxt     = 1'b0;
        fell      = 1'b1;
      end
      PH_ENTRY: begin
        phase_mid = PH_DISPON;
        e_nxt     = 1'b0;
        fell      = 1'b1;
      end
      PH_DISPON: begin
        phase_mid = PH_CLR0;
        e_nxt     = 1'b0;
        fell      = 1'b1;
      end
      PH_CLR0: begin
        phase_mid = PH_READY;
        e_nxt     = 1'b0;
        fell      = 1'b1;
      end
      PH_READY: begin
        if (go) begin
          ready_nxt = 1'b0;
          phase_mid = PH_CLR;
        end
      end
      PH_CLR: begin
        phase_mid = PH_CURSOR;
        e_nxt     = 1'b0;
        fell      = 1'b1;
        col_nxt   = '0;
      end
      PH_CURSOR: begin
        phase_mid = PH_CHAR;
        e_nxt     = 1'b0;
        fell      = 1'b1;
      end
      PH_CHAR: begin
        e_nxt     = 1'b0;
        fell      = 1'b1;
        col_nxt   = col_r + 1'b1;
        phase_mid = (col_nxt < COL_LAST) ? PH_CURSOR : PH_HOLD;
      end
      PH_HOLD: begin
        if (!go) phase_mid = PH_READY;
      end
      default:   phase_mid = PH_INIT1;
    endcase

    // enter the new phase
    unique case (phase_mid) inside
      PH_INIT1:  ready_nxt = 1'b0;
      PH_WAITPU: wait_nxt  = wait_nxt + 1'b1;
      PH_FUNC: begin
        rs_nxt = 1'b0; data_nxt = clcd_pkg::CMD_FUNC_SET; e_nxt = 1'b1;
      end
      PH_ENTRY: begin
        rs_nxt = 1'b0; data_nxt = clcd_pkg::CMD_ENTRY_MODE; e_nxt = 1'b1;
      end
      PH_DISPON: begin
        rs_nxt = 1'b0; data_nxt = clcd_pkg::CMD_DISP_ON; e_nxt = 1'b1;
      end
      PH_CLR0, PH_CLR: begin
        rs_nxt = 1'b0; data_nxt = clcd_pkg::CMD_CLEAR; e_nxt = 1'b1;
      end
      PH_READY:  ready_nxt = 1'b1;
      PH_CURSOR: begin
        rs_nxt = 1'b0;
        e_nxt  = 1'b1;
        if (col_nxt < COL_SPLIT)
          data_nxt = clcd_pkg::DDRAM_ROW0 + 8'(col_nxt);
        else
          data_nxt = clcd_pkg::DDRAM_ROW1 + 8'(col_nxt[clcd_pkg::BUF_AW-1:0]);
      end
      PH_CHAR: begin
        rs_nxt = 1'b1; data_nxt = buf_rdata; e_nxt = 1'b1;
      end
      default: ;
    endcase

    phase_nxt = phase_mid;

    // a buffer write or an idle cycle shows the pins unchanged
    if (step) begin
      res.data  = data_nxt;
      res.rs    = rs_nxt;
      res.e     = e_nxt;
      res.fell  = fell;
      res.ready = ready_nxt;
    end else begin
      res.data  = data_r;
      res.rs    = rs_r;
      res.e     = e_r;
      res.fell  = 1'b0;
      res.ready = ready_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PRE;
      col_r   <= '0;
      wait_r  <= '0;
      data_r  <= '0;
      rs_r    <= 1'b0;
      e_r     <= 1'b0;
      ready_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      col_r   <= col_nxt;
      wait_r  <= wait_nxt;
      data_r  <= data_nxt;
      rs_r    <= rs_nxt;
      e_r     <= e_nxt;
      ready_r <= ready_nxt;
    end
  end

  // ready is shown exactly while parked waiting for go
  a_ready_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r == (phase_r == PH_READY))
    else $error("ready flag out of step with phase");

  // enable is high only inside a write phase
  a_e_phase: assert property (@(posedge clk) disable iff (!rst_n)
    e_r |-> (phase_r == PH_FUNC || phase_r == PH_ENTRY || phase_r == PH_DISPON ||
             phase_r == PH_CLR0 || phase_r == PH_CLR || phase_r == PH_CURSOR ||
             phase_r == PH_CHAR))
    else $error("enable high outside a write phase");

  // a write can only end if one was started
  a_fell_e: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.fell) |-> e_r)
    else $error("enable dropped while already low");

  // column never runs past the display width
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= COL_LAST)
    else $error("column count beyond display width");

endmodule

// ===== rtl/char_lcd_init_and_write_sequencer.sv =====
// top level of the character lcd init and write sequencer
// path: an accepted beat waits in the input register, and the state step carries it into the
//   result register, from which the out_ ports are driven
// throughput: one beat per cycle while out_stall is low, tick or buffer write alike; set by the single
//   state step between the input and result registers
// reset: synchronous active low; control and lcd pin state clear, power-up wait
//   returns to 10, the character buffer holds garbage until written
module char_lcd_init_and_write_sequencer #(
  parameter int COLUMNS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  // config register
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_op,
  input  logic       in_go,
  input  logic [3:0] in_char_index,
  input  logic [7:0] in_char_value,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_bus_data,
  output logic       out_lcd_rs,
  output logic       out_lcd_e,
  output logic       out_e_fell,
  output logic       out_ready_res
);

  // power-up wait register
  logic [7:0] pu_wait_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pu_wait_r <= clcd_pkg::PU_WAIT_RST;
    end else if (cfg_we) begin
      pu_wait_r <= cfg_wdata;
    end
  end

  // input register stage
  logic                         in_v_r;
  logic                         in_op_r;
  logic                         in_go_r;
  logic [clcd_pkg::BUF_AW-1:0]  in_idx_r;
  logic [7:0]                   in_val_r;

  // result register stage
  logic                         out_v_r;
  clcd_pkg::clcd_res_t          out_res_r;

  logic in_take;
  logic adv;

  // the held beat moves on when the result register is empty or being drained
  assign adv      = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_op_r  <= in_op;
      in_go_r  <= in_go;
      in_idx_r <= in_char_index;
      in_val_r <= in_char_value;
    end
  end

  // character buffer, written by write beats and read by the sequencer
  logic [7:0]                   char_buf_r [clcd_pkg::BUF_DEPTH];
  logic [clcd_pkg::BUF_AW-1:0]  buf_addr;
  logic [7:0]                   buf_rdata;

  always_ff @(posedge clk) begin
    if (adv && in_op_r == clcd_pkg::OP_WRITE) begin
      char_buf_r[in_idx_r] <= in_val_r;
    end
  end

  assign buf_rdata = char_buf_r[buf_addr];

  // sequencer steps only on tick beats
  clcd_pkg::clcd_res_t res;
  logic                step_tick;

  assign step_tick = adv && (in_op_r == clcd_pkg::OP_TICK);

  clcd_seq #(
    .COLUMNS (COLUMNS)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step_tick),
    .go            (in_go_r),
    .power_up_wait (pu_wait_r),
    .buf_addr      (buf_addr),
    .buf_rdata     (buf_rdata),
    .res           (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_valid     = out_v_r;
  assign out_bus_data  = out_res_r.data;
  assign out_lcd_rs    = out_res_r.rs;
  assign out_lcd_e     = out_res_r.e;
  assign out_e_fell    = out_res_r.fell;
  assign out_ready_res = out_res_r.ready;

endmodule
